[design/pptd_pkg.sv]
// Package for the priority periodic task dispatcher.
// Holds field widths, command and status codes, the slot record and the serve function.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pptd_pkg;

  localparam int unsigned TaskSlotsDef = 8;
  localparam int unsigned TaskIdW      = 3;
  localparam int unsigned PrioW        = 8;
  localparam int unsigned PeriodW      = 17;
  localparam int unsigned TickW        = 32;
  localparam int unsigned InDataW      = 32;
  localparam int unsigned OutDataW     = 8;

  // Command codes carried in the mode field
  typedef enum logic [3:0] {
    ModeCreate  = 4'd0,
    ModeRemove  = 4'd1,
    ModeChange  = 4'd2,
    ModePeriod  = 4'd3,
    ModeEvent   = 4'd4,
    ModeTrigger = 4'd5,
    ModeStop    = 4'd6,
    ModeTick    = 4'd7,
    ModePass    = 4'd8
  } mode_e;

  // Result status codes
  localparam logic [1:0] StatOk   = 2'd0;
  localparam logic [1:0] StatMiss = 2'd1;
  localparam logic [1:0] StatFull = 2'd2;

  // One task slot as kept in the slot memory
  typedef struct packed {
    logic [PrioW-1:0]          prio;
    logic                      active;
    logic                      pending;
    logic signed [PeriodW-1:0] period;
    logic [TickW-1:0]          next_run;
  } slot_rec_t;

  // Queue update request from the sequencer
  typedef struct packed {
    logic               ins;
    logic               del;
    logic [TaskIdW-1:0] id;
  } q_ctrl_t;

  typedef struct packed {
    logic      hit;
    slot_rec_t rec;
  } serve_t;

  // Serve a slot: pending trigger first, then the period check
  function automatic serve_t serve_slot(slot_rec_t rec, logic [TickW-1:0] tick);
    serve_t r;
    r.hit = 1'b0;
    r.rec = rec;
    if (rec.active) begin
      if (rec.pending) begin
        r.hit         = 1'b1;
        r.rec.pending = 1'b0;
      end else if (!rec.period[PeriodW-1] && (tick >= rec.next_run)) begin
        r.hit          = 1'b1;
        r.rec.next_run = tick + TickW'(rec.period);
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[design/pptd_slot_mem.sv]
// Slot record memory: one write port, one registered read port.
// Per-entry valid bits make an unwritten slot read as an inactive, non-periodic slot.
// Depends on pptd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pptd_slot_mem #(
  parameter int unsigned Depth = pptd_pkg::TaskSlotsDef,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic [AddrW-1:0]    rd_addr_i,
  output pptd_pkg::slot_rec_t      rd_data_o,
  input  wire logic                wr_en_i,
  input  wire logic [AddrW-1:0]    wr_addr_i,
  input  pptd_pkg::slot_rec_t      wr_data_i
);

  pptd_pkg::slot_rec_t mem [Depth];
  pptd_pkg::slot_rec_t rdata_q;
  logic [Depth-1:0]    valid_q;
  logic                rvalid_q;

  // Storage array, no reset
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rdata_q <= mem[rd_addr_i];
  end

  // Written-slot flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      rvalid_q <= valid_q[rd_addr_i];
    end
  end

  // Unwritten slot reads as its reset contents
  always_comb begin
    rd_data_o = rdata_q;
    if (!rvalid_q) begin
      rd_data_o.active   = 1'b0;
      rd_data_o.pending  = 1'b0;
      rd_data_o.period   = '1;
      rd_data_o.next_run = '0;
    end
  end

endmodule

`default_nettype wire

[design/pptd_queue.sv]
// Priority queue of slot numbers: order registers, count, lookup, insert and delete.
// Depends on pptd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pptd_queue #(
  parameter int unsigned Depth = pptd_pkg::TaskSlotsDef,
  parameter int unsigned CntW  = $clog2(Depth + 1)
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  pptd_pkg::q_ctrl_t                  ctrl_i,
  input  wire logic [CntW-1:0]               pos_i,
  input  wire logic [CntW-1:0]               rd_idx_i,
  output logic [pptd_pkg::TaskIdW-1:0]       rd_id_o,
  output logic                               found_o,
  output logic [CntW-1:0]                    found_pos_o,
  output logic [CntW-1:0]                    count_o,
  output logic                               full_o
);

  localparam int unsigned IdxW = (Depth > 1) ? $clog2(Depth) : 1;

  logic [pptd_pkg::TaskIdW-1:0] order_q [Depth];
  logic [pptd_pkg::TaskIdW-1:0] order_d [Depth];
  logic [CntW-1:0]              count_q;

  assign count_o = count_q;
  assign full_o  = (32'(count_q) >= Depth);
  assign rd_id_o = order_q[rd_idx_i[IdxW-1:0]];

  // Lookup of the addressed slot, first match wins
  always_comb begin
    found_o     = 1'b0;
    found_pos_o = '0;
    for (int k = Depth - 1; k >= 0; k--) begin
      if ((k < 32'(count_q)) && (order_q[k] == ctrl_i.id)) begin
        found_o     = 1'b1;
        found_pos_o = CntW'(k);
      end
    end
  end

  // Shift for insert and delete
  always_comb begin
    for (int k = 0; k < Depth; k++) begin
      order_d[k] = order_q[k];
      if (ctrl_i.ins) begin
        if (k == 32'(pos_i)) begin
          order_d[k] = ctrl_i.id;
        end else if ((k > 32'(pos_i)) && (k <= 32'(count_q)) && (k > 0)) begin
          order_d[k] = order_q[k-1];
        end
      end else if (ctrl_i.del) begin
        if ((k >= 32'(pos_i)) && (k + 1 < Depth)) begin
          order_d[k] = order_q[k+1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < Depth; k++) begin
      order_q[k] <= order_d[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (ctrl_i.ins) begin
      count_q <= count_q + CntW'(1);
    end else if (ctrl_i.del) begin
      count_q <= count_q - CntW'(1);
    end
  end

endmodule

`default_nettype wire

[design/priority_periodic_task_dispatcher.sv]
// Top level of the priority periodic task dispatcher: command sequencer and result register.
// Depends on pptd_pkg, pptd_slot_mem and pptd_queue.
//
//  port group   dir  contents
//  s_axis_*     in   command request: tuser mode; tdata task_id, priority_req, period
//  m_axis_*     out  result request: tuser dispatched; tdata status, run_task; tlast final one
//
// One command at a time; s_axis_tready is high only while the sequencer is idle.
// Each slot memory access goes through an address, a read and a use state.
// Create and change walk the queue entry by entry for the insert position.
// Result back-pressure stalls the sequencer. Reset clears queue count, tick and slot flags.
`timescale 1ns / 1ps
`default_nettype none

module priority_periodic_task_dispatcher #(
  parameter int unsigned TASK_SLOTS = pptd_pkg::TaskSlotsDef
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [3:0] mode
  input  wire logic [3:0]                      s_axis_tuser,
  // [2:0] task_id, [10:3] priority_req, [27:11] period, [31:28] zero
  input  wire logic [pptd_pkg::InDataW-1:0]    s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // [0] dispatched
  output logic                                 m_axis_tuser,
  // [1:0] status, [4:2] run_task, [7:5] zero
  output logic [pptd_pkg::OutDataW-1:0]        m_axis_tdata,
  output logic                                 m_axis_tlast
);

  localparam int unsigned IdxW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int unsigned CntW = $clog2(TASK_SLOTS + 1);

  typedef enum logic [3:0] {
    StIdle, StCmd, StRmwWait, StRmwUse, StInsAddr, StInsWait, StInsCmp,
    StPassI, StPassIWait, StPassICur, StPassJ, StPassJWait, StPassJChk,
    StPassC, StPassCWait, StPassCChk
  } state_e;

  state_e state_q, state_d;

  logic [3:0]                        mode_q, mode_d;
  logic [pptd_pkg::TaskIdW-1:0]      id_q, id_d, cur_id_q, cur_id_d;
  logic [pptd_pkg::PrioW-1:0]        prio_q, prio_d, cur_prio_q, cur_prio_d;
  logic signed [pptd_pkg::PeriodW-1:0] period_q, period_d;
  logic [1:0]                        st_q, st_d;
  logic [CntW-1:0]                   k_q, k_d, i_q, i_d, j_q, j_d;
  logic [pptd_pkg::TickW-1:0]        tick_q, tick_d;
  logic [IdxW-1:0]                   rd_addr_q, rd_addr_d;

  logic                              out_valid_q, out_valid_d;
  logic [1:0]                        out_status_q, out_status_d;
  logic                              out_disp_q, out_disp_d;
  logic [pptd_pkg::TaskIdW-1:0]      out_task_q, out_task_d;
  logic                              out_last_q, out_last_d;

  pptd_pkg::slot_rec_t rdata, wr_data;
  pptd_pkg::serve_t    srv;
  logic                wr_en;
  logic [IdxW-1:0]     wr_addr;

  pptd_pkg::q_ctrl_t   qctl;
  logic [CntW-1:0]     qpos, q_rd_idx, q_found_pos, q_count;
  logic [pptd_pkg::TaskIdW-1:0] q_rd_id;
  logic                q_found, q_full;

  logic s_fire, out_free, oob;

  pptd_slot_mem #(.Depth(TASK_SLOTS), .AddrW(IdxW)) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (rd_addr_q),
    .rd_data_o (rdata),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  pptd_queue #(.Depth(TASK_SLOTS), .CntW(CntW)) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (qctl),
    .pos_i       (qpos),
    .rd_idx_i    (q_rd_idx),
    .rd_id_o     (q_rd_id),
    .found_o     (q_found),
    .found_pos_o (q_found_pos),
    .count_o     (q_count),
    .full_o      (q_full)
  );

  assign s_axis_tready = (state_q == StIdle);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign oob           = (32'(id_q) >= TASK_SLOTS);
  assign srv           = pptd_pkg::serve_slot(rdata, tick_q);

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_disp_q;
  assign m_axis_tdata  = {3'b000, out_task_q, out_status_q};
  assign m_axis_tlast  = out_last_q;

  // Queue read index follows the walk in progress
  always_comb begin
    case (state_q)
      StPassI:   q_rd_idx = i_q;
      StPassJ:   q_rd_idx = j_q;
      default:   q_rd_idx = k_q;
    endcase
  end

  // Sequencer next state, memory and queue requests, result capture
  always_comb begin
    state_d      = state_q;
    mode_d       = mode_q;
    id_d         = id_q;
    prio_d       = prio_q;
    period_d     = period_q;
    st_d         = st_q;
    k_d          = k_q;
    i_d          = i_q;
    j_d          = j_q;
    cur_id_d     = cur_id_q;
    cur_prio_d   = cur_prio_q;
    tick_d       = tick_q;
    rd_addr_d    = rd_addr_q;
    wr_en        = 1'b0;
    wr_addr      = rd_addr_q;
    wr_data      = rdata;
    qctl.ins     = 1'b0;
    qctl.del     = 1'b0;
    qctl.id      = id_q;
    qpos         = q_found_pos;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_status_d = out_status_q;
    out_disp_d   = out_disp_q;
    out_task_d   = out_task_q;
    out_last_d   = out_last_q;

    case (state_q)
      StIdle: begin
        if (s_fire) begin
          mode_d   = s_axis_tuser;
          id_d     = s_axis_tdata[2:0];
          prio_d   = s_axis_tdata[10:3];
          period_d = s_axis_tdata[27:11];
          st_d     = pptd_pkg::StatOk;
          state_d  = StCmd;
        end
      end

      // Decode and issue the command, or close it when the result slot is free
      StCmd: begin
        if (mode_q == pptd_pkg::ModeTick) begin
          if (out_free) begin
            tick_d       = tick_q + 32'd1;
            out_valid_d  = 1'b1;
            out_status_d = pptd_pkg::StatOk;
            out_disp_d   = 1'b0;
            out_task_d   = '0;
            out_last_d   = 1'b1;
            state_d      = StIdle;
          end
        end else if (mode_q == pptd_pkg::ModePass) begin
          i_d     = '0;
          state_d = StPassI;
        end else if ((mode_q > pptd_pkg::ModeStop) || oob) begin
          if (out_free) begin
            out_valid_d  = 1'b1;
            out_status_d = oob && (mode_q <= pptd_pkg::ModeStop) ?
                           pptd_pkg::StatMiss : pptd_pkg::StatOk;
            out_disp_d   = 1'b0;
            out_task_d   = '0;
            out_last_d   = 1'b1;
            state_d      = StIdle;
          end
        end else if (mode_q == pptd_pkg::ModeCreate) begin
          wr_en            = 1'b1;
          wr_addr          = IdxW'(id_q);
          wr_data.prio     = prio_q;
          wr_data.active   = 1'b0;
          wr_data.pending  = 1'b0;
          wr_data.period   = '1;
          wr_data.next_run = '0;
          k_d              = '0;
          if (q_found) begin
            st_d    = pptd_pkg::StatMiss;
            state_d = StPassC;
            i_d     = q_count;
          end else if (q_full) begin
            st_d    = pptd_pkg::StatFull;
            state_d = StPassC;
            i_d     = q_count;
          end else begin
            state_d = StInsAddr;
          end
          if (q_found || q_full) begin
            state_d = StPassI;
          end
        end else if (mode_q == pptd_pkg::ModeRemove) begin
          if (q_found) begin
            qctl.del = 1'b1;
          end else begin
            st_d = pptd_pkg::StatMiss;
          end
          i_d     = q_count;
          state_d = StPassI;
        end else begin
          rd_addr_d = IdxW'(id_q);
          state_d   = StRmwWait;
        end
      end

      StRmwWait: state_d = StRmwUse;

      // Read-modify-write of the addressed slot
      StRmwUse: begin
        wr_en = 1'b1;
        case (mode_q)
          pptd_pkg::ModeChange:  wr_data.prio = prio_q;
          pptd_pkg::ModePeriod: begin
            wr_data.active   = 1'b1;
            wr_data.period   = period_q;
            wr_data.next_run = '0;
          end
          pptd_pkg::ModeEvent: begin
            wr_data.active = 1'b1;
            wr_data.period = '1;
          end
          pptd_pkg::ModeTrigger: wr_data.pending = 1'b1;
          default:               wr_data.active  = 1'b0;
        endcase
        if ((mode_q == pptd_pkg::ModeChange) && q_found) begin
          qctl.del = 1'b1;
          k_d      = '0;
          state_d  = StInsAddr;
        end else begin
          i_d     = q_count;
          state_d = StPassI;
        end
      end

      // Walk the queue for the insert position
      StInsAddr: begin
        if (k_q == q_count) begin
          qctl.ins = 1'b1;
          qpos     = k_q;
          i_d      = q_count + CntW'(1);
          state_d  = StPassI;
        end else begin
          rd_addr_d = IdxW'(q_rd_id);
          state_d   = StInsWait;
        end
      end

      StInsWait: state_d = StInsCmp;

      StInsCmp: begin
        if (rdata.prio > prio_q) begin
          qctl.ins = 1'b1;
          qpos     = k_q;
          i_d      = q_count + CntW'(1);
          state_d  = StPassI;
        end else begin
          k_d     = k_q + CntW'(1);
          state_d = StInsAddr;
        end
      end

      // Next queue position of a pass; past the end, the closing result
      StPassI: begin
        if (i_q >= q_count) begin
          if (out_free) begin
            out_valid_d  = 1'b1;
            out_status_d = (mode_q == pptd_pkg::ModePass) ? pptd_pkg::StatOk : st_q;
            out_disp_d   = 1'b0;
            out_task_d   = '0;
            out_last_d   = 1'b1;
            state_d      = StIdle;
          end
        end else begin
          cur_id_d  = q_rd_id;
          rd_addr_d = IdxW'(q_rd_id);
          state_d   = StPassIWait;
        end
      end

      StPassIWait: state_d = StPassICur;

      StPassICur: begin
        cur_prio_d = rdata.prio;
        j_d        = '0;
        state_d    = StPassJ;
      end

      // Rescan the head for strictly more urgent tasks
      StPassJ: begin
        if (j_q == q_count) begin
          state_d = StPassC;
        end else begin
          rd_addr_d = IdxW'(q_rd_id);
          state_d   = StPassJWait;
        end
      end

      StPassJWait: state_d = StPassJChk;

      StPassJChk: begin
        if (rdata.prio >= cur_prio_q) begin
          state_d = StPassC;
        end else if (!srv.hit) begin
          j_d     = j_q + CntW'(1);
          state_d = StPassJ;
        end else if (out_free) begin
          wr_en        = 1'b1;
          wr_data      = srv.rec;
          out_valid_d  = 1'b1;
          out_status_d = pptd_pkg::StatOk;
          out_disp_d   = 1'b1;
          out_task_d   = pptd_pkg::TaskIdW'(rd_addr_q);
          out_last_d   = 1'b0;
          j_d          = j_q + CntW'(1);
          state_d      = StPassJ;
        end
      end

      StPassC: begin
        rd_addr_d = IdxW'(cur_id_q);
        state_d   = StPassCWait;
      end

      StPassCWait: state_d = StPassCChk;

      // Serve the task at the current position
      StPassCChk: begin
        if (!srv.hit) begin
          i_d     = i_q + CntW'(1);
          state_d = StPassI;
        end else if (out_free) begin
          wr_en        = 1'b1;
          wr_data      = srv.rec;
          out_valid_d  = 1'b1;
          out_status_d = pptd_pkg::StatOk;
          out_disp_d   = 1'b1;
          out_task_d   = pptd_pkg::TaskIdW'(rd_addr_q);
          out_last_d   = 1'b0;
          i_d          = i_q + CntW'(1);
          state_d      = StPassI;
        end
      end

      default: state_d = StIdle;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      tick_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      tick_q      <= tick_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Command and walk registers
  always_ff @(posedge clk_i) begin
    mode_q       <= mode_d;
    id_q         <= id_d;
    prio_q       <= prio_d;
    period_q     <= period_d;
    st_q         <= st_d;
    k_q          <= k_d;
    i_q          <= i_d;
    j_q          <= j_d;
    cur_id_q     <= cur_id_d;
    cur_prio_q   <= cur_prio_d;
    rd_addr_q    <= rd_addr_d;
    out_status_q <= out_status_d;
    out_disp_q   <= out_disp_d;
    out_task_q   <= out_task_d;
    out_last_q   <= out_last_d;
  end

  // Queue never holds more entries than slots
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(q_count) <= TASK_SLOTS) else $error("queue count exceeds slots");

  // A request is taken only once per command
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire |=> !s_axis_tready) else $error("second request taken mid-command");

  // Only dispatch results are non-final
  a_disp_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tlast) |-> m_axis_tuser)
    else $error("non-final result without dispatch");

  // Queue changes only outside a pass
  a_pass_queue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == pptd_pkg::ModePass && state_q != StIdle && state_q != StCmd) |->
    (!qctl.ins && !qctl.del)) else $error("queue modified during pass");

endmodule

`default_nettype wire

[tb/pptd_result_checker.sv]
// Result checker for the priority periodic task dispatcher.
// Watches both stream channels, predicts the results of every accepted command and compares.
// Depends on pptd_pkg.
`timescale 1ns / 1ps

module pptd_result_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [3:0]  s_axis_tuser,
  input  logic [31:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic        m_axis_tuser,
  input  logic [7:0]  m_axis_tdata,
  input  logic        m_axis_tlast,
  output int          mismatch_cnt_o,
  output int          due_cnt_o
);
  import pptd_pkg::*;

  localparam int Slots = 8;

  typedef struct {
    logic [1:0] status;
    logic       dispatched;
    logic [2:0] run_task;
    logic       last;
  } dispatch_res_t;

  // Shadow copy of the dispatcher state
  logic [2:0]                  queue_ids [Slots];
  int                          queue_len;
  logic [PrioW-1:0]            task_prio [Slots];
  logic                        task_act  [Slots];
  logic                        task_pend [Slots];
  logic signed [PeriodW-1:0]   task_per  [Slots];
  logic [TickW-1:0]            task_due  [Slots];
  logic [TickW-1:0]            tick_now;

  dispatch_res_t due_q[$];
  int            mismatches;

  assign mismatch_cnt_o = mismatches;
  assign due_cnt_o      = due_q.size();

  function automatic int queue_pos(logic [2:0] id);
    for (int i = 0; i < queue_len; i++) begin
      if (queue_ids[i] == id) return i;
    end
    return -1;
  endfunction

  // Insert behind all entries of equal priority; 0 inserted, 1 already queued, 2 full
  function automatic logic [1:0] queue_insert(logic [2:0] id);
    int pos;
    if (queue_pos(id) >= 0) return StatMiss;
    if (queue_len >= Slots) return StatFull;
    pos = queue_len;
    for (int k = 0; k < queue_len; k++) begin
      if (task_prio[queue_ids[k]] > task_prio[id]) begin
        pos = k;
        break;
      end
    end
    for (int k = queue_len; k > pos; k--) queue_ids[k] = queue_ids[k-1];
    queue_ids[pos] = id;
    queue_len++;
    return StatOk;
  endfunction

  function automatic logic [1:0] queue_remove(logic [2:0] id);
    int f;
    f = queue_pos(id);
    if (f < 0) return StatMiss;
    queue_len--;
    for (int k = f; k < queue_len; k++) queue_ids[k] = queue_ids[k+1];
    return StatOk;
  endfunction

  // Trigger wins over the period check
  function automatic bit try_run(logic [2:0] id);
    if (!task_act[id]) return 0;
    if (task_pend[id]) begin
      task_pend[id] = 1'b0;
      return 1;
    end
    if (!task_per[id][PeriodW-1] && tick_now >= task_due[id]) begin
      task_due[id] = tick_now + TickW'(unsigned'(task_per[id]));
      return 1;
    end
    return 0;
  endfunction

  function automatic void push_run(logic [2:0] id);
    dispatch_res_t r;
    r = '{StatOk, 1'b1, id, 1'b0};
    due_q.push_back(r);
  endfunction

  function automatic void predict_command(logic [3:0] u, logic [31:0] d);
    mode_e                     mode;
    logic [2:0]                id;
    logic [PrioW-1:0]          prio;
    logic signed [PeriodW-1:0] per;
    logic [1:0]                st;
    logic [2:0]                cur, oth;
    dispatch_res_t             r;
    mode = mode_e'(u);
    id   = d[2:0];
    prio = d[10:3];
    per  = d[27:11];
    st   = StatOk;
    case (mode)
      ModeCreate: begin
        task_act[id]  = 1'b0;
        task_pend[id] = 1'b0;
        task_per[id]  = -1;
        task_prio[id] = prio;
        task_due[id]  = '0;
        st = queue_insert(id);
      end
      ModeRemove: st = queue_remove(id);
      ModeChange: begin
        task_prio[id] = prio;
        if (queue_remove(id) == StatOk) void'(queue_insert(id));
      end
      ModePeriod: begin
        task_act[id] = 1'b1;
        task_per[id] = per;
        task_due[id] = '0;
      end
      ModeEvent: begin
        task_act[id] = 1'b1;
        task_per[id] = -1;
      end
      ModeTrigger: task_pend[id] = 1'b1;
      ModeStop:    task_act[id]  = 1'b0;
      ModeTick:    tick_now++;
      ModePass: begin
        for (int i = 0; i < queue_len; i++) begin
          cur = queue_ids[i];
          // more urgent tasks from the head get a turn first
          for (int j = 0; j < queue_len; j++) begin
            oth = queue_ids[j];
            if (task_prio[oth] >= task_prio[cur]) break;
            if (try_run(oth)) push_run(oth);
          end
          if (try_run(cur)) push_run(cur);
        end
      end
      default: ;
    endcase
    r = '{st, 1'b0, 3'd0, 1'b1};
    due_q.push_back(r);
  endfunction

  function automatic void compare_result(logic [7:0] d, logic u, logic l);
    dispatch_res_t e;
    if (due_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: result with none expected: data %h user %b last %b",
                 $realtime, d, u, l);
      return;
    end
    e = due_q.pop_front();
    if (d[1:0] !== e.status || u !== e.dispatched || d[4:2] !== e.run_task ||
        d[7:5] !== 3'b000 || l !== e.last) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: mismatch: status %0d/%0d dispatched %b/%b task %0d/%0d last %b/%b pad %b",
                 $realtime, e.status, d[1:0], e.dispatched, u, e.run_task, d[4:2],
                 e.last, l, d[7:5]);
    end
  endfunction

  // Track both channels on each clock edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      queue_len  <= 0;
      tick_now   <= '0;
      mismatches <= 0;
      for (int s = 0; s < Slots; s++) begin
        task_act[s]  <= 1'b0;
        task_pend[s] <= 1'b0;
        task_per[s]  <= -1;
        task_due[s]  <= '0;
        task_prio[s] <= '0;
        queue_ids[s] <= '0;
      end
    end else begin
      if (m_axis_tvalid && m_axis_tready)
        compare_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
      if (s_axis_tvalid && s_axis_tready) predict_command(s_axis_tuser, s_axis_tdata);
    end
  end

endmodule

[tb/priority_periodic_task_dispatcher_tb.sv]
// Testbench top for the priority periodic task dispatcher: clock, reset, command stimulus.
// Depends on pptd_pkg, the dispatcher RTL and pptd_result_checker.
`timescale 1ns / 1ps

module priority_periodic_task_dispatcher_tb;
  import pptd_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [3:0]  s_axis_tuser = '0;
  logic [31:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic        m_axis_tuser;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;
  int          mismatch_cnt, due_cnt;

  bit quiet_run  = 0;   // no idling on either side
  int long_hold  = 0;   // receiver hold-off request, in cycles
  int idle_count = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  priority_periodic_task_dispatcher dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tuser, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tuser, .m_axis_tdata, .m_axis_tlast
  );

  pptd_result_checker chk (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tuser, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tuser, .m_axis_tdata, .m_axis_tlast,
    .mismatch_cnt_o(mismatch_cnt), .due_cnt_o(due_cnt)
  );

  // Receiver: random stall bursts plus one long hold-off
  always @(posedge clk_i) begin
    if (long_hold > 0) begin
      m_axis_tready <= 1'b0;
      long_hold <= long_hold - 1;
    end else if (idle_count > 0) begin
      m_axis_tready <= 1'b0;
      idle_count <= idle_count - 1;
    end else if (!quiet_run && $urandom_range(0, 7) == 0) begin
      m_axis_tready <= 1'b0;
      idle_count <= $urandom_range(1, 19) - 1;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Watchdog on cycles with no request moving
  int stuck = 0;
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) stuck <= 0;
    else stuck <= stuck + 1;
    if (stuck >= 4000) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_cmd(mode_e mode, logic [2:0] id, logic [7:0] prio, logic [16:0] per);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= {4'b0000, per, prio, id};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (!quiet_run && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
  endtask

  task automatic send_random(int n);
    int          pick;
    logic [2:0]  id;
    logic [16:0] per;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      id   = $urandom_range(0, 7);
      per  = ($urandom_range(0, 9) == 0) ? 17'($urandom) : 17'($urandom_range(0, 6));
      if (pick < 12)      send_cmd(ModeCreate, id, 8'($urandom_range(0, 3) * 60 +
                                     $urandom_range(0, 1)), 17'($urandom));
      else if (pick < 16) send_cmd(ModeRemove, id, 8'($urandom), 17'($urandom));
      else if (pick < 21) send_cmd(ModeChange, id, 8'($urandom), 17'($urandom));
      else if (pick < 33) send_cmd(ModePeriod, id, 8'($urandom), per);
      else if (pick < 38) send_cmd(ModeEvent, id, 8'($urandom), 17'($urandom));
      else if (pick < 48) send_cmd(ModeTrigger, id, 8'($urandom), 17'($urandom));
      else if (pick < 52) send_cmd(ModeStop, id, 8'($urandom), 17'($urandom));
      else if (pick < 72) send_cmd(ModeTick, id, 8'($urandom), 17'($urandom));
      else if (pick < 97) send_cmd(ModePass, id, 8'($urandom), 17'($urandom));
      else                send_cmd(mode_e'($urandom_range(9, 15)), id, 8'($urandom),
                                   17'($urandom));
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: priority extremes, equal priorities, every command kind
    send_cmd(ModeRemove,  3'd0, 8'd0,   17'd0);        // not queued
    send_cmd(ModeCreate,  3'd0, 8'd255, 17'h1ffff);
    send_cmd(ModeCreate,  3'd1, 8'd0,   17'd0);
    send_cmd(ModeCreate,  3'd2, 8'd100, 17'd0);
    send_cmd(ModeCreate,  3'd3, 8'd100, 17'd0);        // behind its equal
    send_cmd(ModeCreate,  3'd2, 8'd50,  17'd0);        // already queued, keeps place
    send_cmd(ModePeriod,  3'd0, 8'd0,   17'd0);        // period zero
    send_cmd(ModePeriod,  3'd1, 8'd0,   17'hffff);     // largest period
    send_cmd(ModePeriod,  3'd2, 8'd0,   17'h1ffff);    // negative: not periodic
    send_cmd(ModeEvent,   3'd3, 8'd0,   17'd0);
    send_cmd(ModeTrigger, 3'd3, 8'd0,   17'd0);
    send_cmd(ModeTrigger, 3'd7, 8'd0,   17'd0);        // slot not queued
    send_cmd(ModePass,    3'd0, 8'd0,   17'd0);
    send_cmd(ModeTick,    3'd0, 8'd0,   17'd0);
    send_cmd(ModeChange,  3'd0, 8'd0,   17'd0);        // moves up behind its equal at the head
    send_cmd(ModeChange,  3'd6, 8'd9,   17'd0);        // not queued
    send_cmd(ModeTrigger, 3'd2, 8'd0,   17'd0);
    send_cmd(ModePass,    3'd0, 8'd0,   17'd0);
    send_cmd(ModeStop,    3'd0, 8'd0,   17'd0);
    send_cmd(ModeRemove,  3'd1, 8'd0,   17'd0);
    send_cmd(mode_e'(4'd15), 3'd5, 8'hff, 17'h1ffff); // unused code
    send_cmd(mode_e'(4'd9),  3'd0, 8'd0,  17'd0);
    for (int s = 4; s < 8; s++) send_cmd(ModeCreate, 3'(s), 8'(s * 30), 17'd0);
    send_cmd(ModePass,    3'd0, 8'd0,   17'd0);

    send_random(150);

    // Receiver holds off while commands keep coming
    long_hold = 600;
    send_random(40);

    // Drain fully, then carry on
    s_axis_tvalid <= 1'b0;
    wait (due_cnt == 0);
    repeat (300) @(posedge clk_i);
    send_random(180);

    quiet_run = 1;
    send_random(70);
    s_axis_tvalid <= 1'b0;

    wait (due_cnt == 0);
    repeat (300) @(posedge clk_i);
    if (mismatch_cnt == 0 && due_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
